@@ rtl/max_heap_priority_queue_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the max heap priority queue unit
// Concurrent checks are compiled for simulation and drop out in synthesis.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property check, disabled while reset is asserted.
`define MHPQ_CHECK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition in one cycle leads to a result in the next cycle.
`define MHPQ_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MHPQ_CHECK(label, clk, rst_n, prop, msg)

`define MHPQ_CHECK_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// Max heap priority queue package
// Shared widths, codes and types for the sorted cell chain.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CAPACITY    = 128;
    localparam int KEY_W       = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int COUNT_OUT_W = 8;
    localparam int STATUS_W    = 2;

    // Match reduction tree: groups of eight cells in the first stage.
    localparam int GRP_W        = 8;
    localparam int MATCH_GROUPS = (CAPACITY + GRP_W - 1) / GRP_W;
    localparam int MATCH_PAD_W  = MATCH_GROUPS * GRP_W;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef logic signed [KEY_W-1:0] t_key;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
    } t_cell_ctl;

endpackage

@@ rtl/mhpq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted chain cell
// Holds one key of the descending chain and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module mhpq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mhpq_pkg::t_cell_ctl i_ctl,
    input  mhpq_pkg::t_key      i_key,
    input  mhpq_pkg::t_key      i_prev_value,
    input  logic                i_prev_valid,
    input  logic                i_prev_keep,
    input  mhpq_pkg::t_key      i_next_value,
    input  logic                i_next_valid,
    output mhpq_pkg::t_key      o_value,
    output logic                o_valid,
    output logic                o_keep,
    output logic                o_eq
);
    import mhpq_pkg::*;

    t_key r_value;
    t_key n_value;
    logic r_valid;
    logic n_valid;
    logic r_keep;
    logic r_eq;

    // A cell keeps its place when it holds a key strictly above the
    // operand; every other valid cell lies at or below the operand.
    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.ins_en) begin
            if (!r_keep) begin
                if (i_prev_keep) begin
                    n_value = i_key;
                    n_valid = 1'b1;
                end else begin
                    n_value = i_prev_value;
                    n_valid = i_prev_valid;
                end
            end
        end else if (i_ctl.del_en) begin
            if (r_valid && !r_keep) begin
                n_value = i_next_value;
                n_valid = i_next_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_keep  <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_ctl.cmp_en) begin
                r_keep <= r_valid && (r_value > i_key);
                r_eq   <= r_valid && (r_value == i_key);
            end
        end
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_keep  = r_keep;
    assign o_eq    = r_eq;

endmodule

@@ rtl/mhpq_match_tree.sv @@
// ----------------------------------------------------------------------------
// Match reduction tree
// Two registered OR stages that report whether any cell matched the key.
// ----------------------------------------------------------------------------
module mhpq_match_tree (
    input  logic                          i_clk,
    input  logic [mhpq_pkg::CAPACITY-1:0] i_eq,
    output logic                          o_any
);
    import mhpq_pkg::*;

    logic [MATCH_PAD_W-1:0]  w_pad;
    logic [MATCH_GROUPS-1:0] r_grp;
    logic                    r_any;

    assign w_pad = MATCH_PAD_W'(i_eq);

    for (genvar g = 0; g < MATCH_GROUPS; g++) begin : g_grp
        always_ff @(posedge i_clk) begin
            r_grp[g] <= |w_pad[g*GRP_W +: GRP_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_any <= |r_grp;
    end

    assign o_any = r_any;

endmodule

@@ rtl/max_heap_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// Max heap priority queue unit
// Priority queue of signed keys held as a descending chain of cells.
//
//   Channel  Handshake          Payload
//   input    i_valid / o_stall  i_op, i_value
//   output   o_valid / i_stall  o_status, o_count, o_top_value, o_top_valid
//
// Each item passes from its transfer through S_CMP, which registers the
// per-cell compares, S_RED1 and S_RED2 for the registered match tree, S_APPLY,
// which shifts the chain, and S_RESULT, which loads the output register. The
// next transfer is taken only after the load, so items never overlap.
// A new item is taken as soon as the sequencer is idle, even while the last
// result still waits in the output register; that item then holds in its
// last step until the waiting result has been taken.
// Reset is synchronous and empties the chain at once; no clearing pass. The
// input stalls while reset is asserted.
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_unit_defines.svh"

module max_heap_priority_queue_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_op,
    input  mhpq_pkg::t_key                    i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [mhpq_pkg::STATUS_W-1:0]     o_status,
    output logic [mhpq_pkg::COUNT_OUT_W-1:0]  o_count,
    output mhpq_pkg::t_key                    o_top_value,
    output logic                              o_top_valid
);
    import mhpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_RED1,
        S_RED2,
        S_APPLY,
        S_RESULT
    } t_state;

    t_state                r_state;
    logic                  r_op;
    t_key                  r_key;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [STATUS_W-1:0]   r_status;
    logic [STATUS_W-1:0]   n_status;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [COUNT_OUT_W-1:0] r_out_count;
    t_key                  r_out_top_value;
    logic                  r_out_top_valid;

    t_cell_ctl             w_ctl;
    logic                  w_full;
    logic                  w_any;
    logic                  w_out_load;

    t_key                  w_value      [CAPACITY];
    t_key                  w_prev_value [CAPACITY];
    t_key                  w_next_value [CAPACITY];
    logic [CAPACITY-1:0]   w_valid;
    logic [CAPACITY-1:0]   w_keep;
    logic [CAPACITY-1:0]   w_eq;
    logic [CAPACITY-1:0]   w_prev_valid;
    logic [CAPACITY-1:0]   w_prev_keep;
    logic [CAPACITY-1:0]   w_next_valid;

    assign w_full = (r_count == CNT_W'(CAPACITY));

    // Load only once the previous result has been taken.
    assign w_out_load = (r_state == S_RESULT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_status = STATUS_OK;
        n_count  = r_count;
        if (r_op == OP_INSERT) begin
            if (w_full) begin
                n_status = STATUS_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (!w_any) begin
                n_status = STATUS_NOT_FOUND;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    assign w_ctl.cmp_en = (r_state == S_CMP);
    assign w_ctl.ins_en = (r_state == S_APPLY) && (r_op == OP_INSERT) && !w_full;
    assign w_ctl.del_en = (r_state == S_APPLY) && (r_op == OP_DELETE) && w_any;

    // The head cell sees a virtual neighbor above it that always keeps its
    // place, so an insert that beats every key lands at the head.
    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        if (c == 0) begin : g_head
            assign w_prev_value[c] = r_key;
            assign w_prev_valid[c] = 1'b1;
            assign w_prev_keep[c]  = 1'b1;
        end else begin : g_body
            assign w_prev_value[c] = w_value[c-1];
            assign w_prev_valid[c] = w_valid[c-1];
            assign w_prev_keep[c]  = w_keep[c-1];
        end

        if (c == CAPACITY - 1) begin : g_tail
            assign w_next_value[c] = '0;
            assign w_next_valid[c] = 1'b0;
        end else begin : g_link
            assign w_next_value[c] = w_value[c+1];
            assign w_next_valid[c] = w_valid[c+1];
        end

        mhpq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (r_key),
            .i_prev_value (w_prev_value[c]),
            .i_prev_valid (w_prev_valid[c]),
            .i_prev_keep  (w_prev_keep[c]),
            .i_next_value (w_next_value[c]),
            .i_next_valid (w_next_valid[c]),
            .o_value      (w_value[c]),
            .o_valid      (w_valid[c]),
            .o_keep       (w_keep[c]),
            .o_eq         (w_eq[c])
        );
    end

    mhpq_match_tree u_match_tree (
        .i_clk (i_clk),
        .i_eq  (w_eq),
        .o_any (w_any)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_op;
                        r_key   <= i_value;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_RED1;
                end
                S_RED1: begin
                    r_state <= S_RED2;
                end
                S_RED2: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_status <= n_status;
                    r_count  <= n_count;
                    r_state  <= S_RESULT;
                end
                S_RESULT: begin
                    if (w_out_load) begin
                        r_out_status    <= r_status;
                        r_out_count     <= COUNT_OUT_W'(r_count);
                        r_out_top_value <= w_valid[0] ? w_value[0] : '0;
                        r_out_top_valid <= w_valid[0];
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall     = !i_rst_n || (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;
    assign o_top_value = r_out_top_value;
    assign o_top_valid = r_out_top_valid;

    // The occupied cells always form an unbroken run from the head.
    `MHPQ_CHECK(a_valid_prefix, i_clk, i_rst_n,
        (w_valid & (w_valid + 1'b1)) == '0, "occupied cells are not contiguous")

    `MHPQ_CHECK(a_count_matches, i_clk, i_rst_n,
        $countones(w_valid) == r_count, "entry count disagrees with the chain")

    `MHPQ_CHECK(a_head_is_max, i_clk, i_rst_n,
        !w_valid[1] || !(w_value[1] > w_value[0]), "head cell is not the maximum")

    `MHPQ_CHECK_NEXT(a_delete_shrinks, i_clk, i_rst_n,
        w_ctl.del_en, r_count == $past(r_count) - 1'b1, "delete did not shrink the count")

endmodule

@@ verif/max_heap_priority_queue_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max heap priority queue checker
// Watches both channels of the unit. Each input transfer is applied to a
// binary max-heap kept here, and the status, count and maximum it yields are
// queued. Each output transfer is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_checker
    import mhpq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic                    i_op,
    input  t_key                    i_value,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [STATUS_W-1:0]     i_status,
    input  logic [COUNT_OUT_W-1:0]  i_count,
    input  t_key                    i_top_value,
    input  logic                    i_top_valid,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_insert_count,
    output int                      o_delete_count,
    output int                      o_full_count,
    output int                      o_not_found_count,
    output int                      o_peak_depth
);

    typedef struct {
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] count;
        t_key                   top_value;
        logic                   top_valid;
    } heap_result_t;

    t_key         heap_mem [CAPACITY];
    int unsigned  heap_len;
    heap_result_t queue_state_q [$];

    int fail_count    = 0;
    int checked       = 0;
    int insert_count  = 0;
    int delete_count  = 0;
    int full_count    = 0;
    int missing_count = 0;
    int peak_depth    = 0;
    int pending       = 0;

    assign o_fail_count      = fail_count;
    assign o_pending         = pending;
    assign o_checked         = checked;
    assign o_insert_count    = insert_count;
    assign o_delete_count    = delete_count;
    assign o_full_count      = full_count;
    assign o_not_found_count = missing_count;
    assign o_peak_depth      = peak_depth;

    task automatic report_mismatch(input string msg);
        fail_count++;
        // Keep the log short when the unit is badly broken.
        if (fail_count <= 30) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    function automatic void heap_sift_up(int unsigned pos);
        t_key        key;
        int unsigned par;
        key = heap_mem[pos];
        while (pos > 0) begin
            par = (pos - 1) / 2;
            if (!(key > heap_mem[par])) break;
            heap_mem[pos] = heap_mem[par];
            pos = par;
        end
        heap_mem[pos] = key;
    endfunction

    function automatic void heap_sift_down(int unsigned pos);
        int unsigned left;
        int unsigned right;
        int unsigned pick;
        t_key        tmp;
        forever begin
            left  = 2 * pos + 1;
            right = left + 1;
            if (left >= heap_len) break;
            // Equal children go left; a swap needs a strictly larger child.
            pick = left;
            if (right < heap_len && heap_mem[right] > heap_mem[left]) pick = right;
            if (!(heap_mem[pick] > heap_mem[pos])) break;
            tmp            = heap_mem[pos];
            heap_mem[pos]  = heap_mem[pick];
            heap_mem[pick] = tmp;
            pos            = pick;
        end
    endfunction

    function automatic heap_result_t apply_heap_op(logic op, t_key value);
        heap_result_t res;
        int unsigned  pos;
        res.status = STATUS_OK;
        if (op == OP_INSERT) begin
            if (heap_len >= CAPACITY) begin
                res.status = STATUS_FULL;
            end else begin
                heap_mem[heap_len] = value;
                heap_sift_up(heap_len);
                heap_len++;
            end
        end else begin
            pos = heap_len;
            for (int unsigned i = 0; i < heap_len; i++) begin
                if (heap_mem[i] == value) begin
                    pos = i;
                    break;
                end
            end
            if (pos >= heap_len) begin
                res.status = STATUS_NOT_FOUND;
            end else begin
                heap_len--;
                // Removing the last slot needs no repair.
                if (pos < heap_len) begin
                    heap_mem[pos] = heap_mem[heap_len];
                    if (pos > 0 && heap_mem[pos] > heap_mem[(pos - 1) / 2]) begin
                        heap_sift_up(pos);
                    end else begin
                        heap_sift_down(pos);
                    end
                end
            end
        end
        res.count     = heap_len[COUNT_OUT_W-1:0];
        res.top_valid = (heap_len > 0);
        res.top_value = (heap_len > 0) ? heap_mem[0] : '0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        heap_result_t want;
        heap_result_t got;
        if (!i_rst_n) begin
            heap_len = 0;
            queue_state_q.delete();
            pending = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (queue_state_q.size() == 0) begin
                    report_mismatch("result transfer with no item outstanding");
                end else begin
                    want = queue_state_q.pop_front();
                    checked++;
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status: got %0d, expected %0d",
                                                  i_status, want.status));
                    end
                    if (i_count !== want.count) begin
                        report_mismatch($sformatf("count: got %0d, expected %0d",
                                                  i_count, want.count));
                    end
                    if (i_top_value !== want.top_value) begin
                        report_mismatch($sformatf("top_value: got %0d, expected %0d",
                                                  i_top_value, want.top_value));
                    end
                    if (i_top_valid !== want.top_valid) begin
                        report_mismatch($sformatf("top_valid: got %0d, expected %0d",
                                                  i_top_valid, want.top_valid));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                got = apply_heap_op(i_op, i_value);
                queue_state_q.push_back(got);
                if (i_op == OP_INSERT) insert_count++;
                else delete_count++;
                if (got.status == STATUS_FULL) full_count++;
                if (got.status == STATUS_NOT_FOUND) missing_count++;
                if (int'(heap_len) > peak_depth) peak_depth = heap_len;
            end
            pending = queue_state_q.size();
        end
    end

endmodule

@@ verif/max_heap_priority_queue_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max heap priority queue unit testbench
// Drives a directed sequence of inserts and deletes, then random phases that
// fill the heap past capacity, drain it to empty and mix both, with random
// idling on both channels and one long output hold-off. The checker predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit_test;
    import mhpq_pkg::*;

    localparam int TOTAL_ITEMS    = 1500;
    localparam int QUIET_ITEMS    = 200;
    localparam int HOLD_AT_ITEM   = 700;
    localparam int HOLD_CYCLES    = 400;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 20;

    localparam t_key KEY_MAX = 32'h7FFF_FFFF;
    localparam t_key KEY_MIN = 32'h8000_0000;

    typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_t;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic                   o_stall;
    logic                   i_op        = OP_INSERT;
    t_key                   i_value     = '0;
    logic                   o_valid;
    logic                   i_stall     = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic [COUNT_OUT_W-1:0] o_count;
    t_key                   o_top_value;
    logic                   o_top_valid;

    int fail_count;
    int pending;
    int checked;
    int insert_count;
    int delete_count;
    int full_count;
    int not_found_count;
    int peak_depth;

    int   items_sent       = 0;
    bit   quiet            = 1'b0;
    bit   hold_off_request = 1'b0;
    int   idle_cycles      = 0;
    t_key live_keys [$];

    max_heap_priority_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_top_value (o_top_value),
        .o_top_valid (o_top_valid)
    );

    max_heap_priority_queue_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_op              (i_op),
        .i_value           (i_value),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_status          (o_status),
        .i_count           (o_count),
        .i_top_value       (o_top_value),
        .i_top_valid       (o_top_valid),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_insert_count    (insert_count),
        .o_delete_count    (delete_count),
        .o_full_count      (full_count),
        .o_not_found_count (not_found_count),
        .o_peak_depth      (peak_depth)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Ends the run when neither channel has moved a transfer for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("max_heap_priority_queue_unit: mismatch");
                $finish;
            end
        end
    end

    // Output side: random stall bursts, one long hold-off on request.
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_off_request) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_request = 1'b0;
            end else if (quiet) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 40);
                i_stall <= 1'b0;
                repeat (n) @(posedge i_clk);
                n = $urandom_range(1, 15);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Keeps the set of stored keys so that most deletes hit a stored copy.
    task automatic send_item(input logic op, input t_key value);
        int gap;
        if (op == OP_INSERT) begin
            if (live_keys.size() < CAPACITY) live_keys.push_back(value);
        end else begin
            for (int i = 0; i < live_keys.size(); i++) begin
                if (live_keys[i] == value) begin
                    live_keys.delete(i);
                    break;
                end
            end
        end
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic t_key random_key();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            // A narrow band of keys gives plenty of duplicates and ties.
            return t_key'(int'($urandom_range(0, 8)) - 4);
        end else if (sel < 55) begin
            case ($urandom_range(0, 3))
                0: return KEY_MAX;
                1: return KEY_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        return t_key'($urandom());
    endfunction

    function automatic t_key delete_key();
        if (live_keys.size() > 0 && $urandom_range(0, 99) < 80) begin
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        end
        return random_key();
    endfunction

    initial begin
        phase_t kind;
        int     len;
        int     insert_pct;
        bit     first_phase;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty delete, extremes, last-slot delete, root delete,
        // absent key, moved entry sifting up, and a tie between children.
        send_item(OP_DELETE, 32'sd5);
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, KEY_MAX);
        send_item(OP_INSERT, KEY_MIN);
        send_item(OP_INSERT, '1);
        send_item(OP_INSERT, KEY_MAX);
        send_item(OP_DELETE, '0);
        send_item(OP_DELETE, KEY_MIN);
        send_item(OP_DELETE, KEY_MAX);
        send_item(OP_DELETE, 32'sd12345);
        send_item(OP_DELETE, KEY_MAX);
        send_item(OP_DELETE, '1);
        send_item(OP_INSERT, 32'sd100);
        send_item(OP_INSERT, 32'sd50);
        send_item(OP_INSERT, 32'sd90);
        send_item(OP_INSERT, 32'sd10);
        send_item(OP_INSERT, 32'sd20);
        send_item(OP_INSERT, 32'sd80);
        send_item(OP_INSERT, 32'sd85);
        send_item(OP_DELETE, 32'sd10);
        send_item(OP_DELETE, 32'sd100);
        send_item(OP_INSERT, 32'sd85);
        send_item(OP_DELETE, 32'sd90);
        send_item(OP_INSERT, KEY_MIN);

        first_phase = 1'b1;
        while (items_sent < TOTAL_ITEMS) begin
            // The first phase always overfills the heap.
            kind = first_phase ? PHASE_FILL : phase_t'($urandom_range(0, 2));
            first_phase = 1'b0;
            case (kind)
                PHASE_FILL: begin
                    len        = $urandom_range(160, 200);
                    insert_pct = 90;
                end
                PHASE_DRAIN: begin
                    len        = $urandom_range(150, 200);
                    insert_pct = 10;
                end
                default: begin
                    len        = $urandom_range(50, 100);
                    insert_pct = 50;
                end
            endcase
            for (int k = 0; k < len && items_sent < TOTAL_ITEMS; k++) begin
                if (items_sent == HOLD_AT_ITEM) hold_off_request = 1'b1;
                if (items_sent >= TOTAL_ITEMS - QUIET_ITEMS) quiet = 1'b1;
                if ($urandom_range(0, 99) < insert_pct) begin
                    send_item(OP_INSERT, random_key());
                end else begin
                    send_item(OP_DELETE, delete_key());
                end
            end
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts and %0d deletes, %0d results checked.",
                 insert_count, delete_count, checked);
        $display("Inserts dropped on a full heap: %0d, deletes of absent keys: %0d, peak depth %0d.",
                 full_count, not_found_count, peak_depth);
        if (fail_count == 0) begin
            $display("max_heap_priority_queue_unit: match");
        end else begin
            $display("max_heap_priority_queue_unit: mismatch");
        end
        $finish;
    end

endmodule
